>>> design/bitmap_frame_allocator_unit_defines.svh
// Assertion macros used by the checker file of the frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bfa_pkg.sv
// Package of the frame allocator: defaults, request and status codes, shared types.
package bfa_pkg;
	localparam int MAX_FRAMES_DEF  = 32768;
	localparam int FRAME_SHIFT_DEF = 12;
	localparam int WORD_BITS_DEF   = 32;

	// Width of a frame count handed to the counter (covers the largest bitmap).
	localparam int HITS_W = 21;

	localparam logic [2:0] REQ_ALLOC_ONE   = 3'd0;
	localparam logic [2:0] REQ_ALLOC_RUN   = 3'd1;
	localparam logic [2:0] REQ_FREE_ONE    = 3'd2;
	localparam logic [2:0] REQ_REGION_FREE = 3'd3;
	localparam logic [2:0] REQ_REGION_USED = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_MEM   = 2'd1;
	localparam logic [1:0] ST_ZERO_LEN = 2'd2;

	typedef struct packed {
		logic [15:0]       fc;
		logic [15:0]       total;
		logic [HITS_W-1:0] n;
		logic              up;
	} cnt_req_t;

	typedef struct packed {
		logic [15:0] fc;
		logic [15:0] teff;
	} cnt_rsp_t;
endpackage

>>> design/bfa_if.sv
// Request and response channel interfaces of the frame allocator.
interface bfa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] address;
	logic [31:0] byte_length;
	logic [15:0] frame_count;

	modport source (output valid, req_type, address, byte_length, frame_count, input ready);
	modport sink (input valid, req_type, address, byte_length, frame_count, output ready);
endinterface

interface bfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [15:0] free_frames;

	modport source (output valid, status, result_address, free_frames, input ready);
	modport sink (input valid, status, result_address, free_frames, output ready);
endinterface

>>> design/bfa_bitmap_ram.sv
// Bitmap word memory: one write port and one registered read port.
module bfa_bitmap_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

>>> design/bfa_count_unit.sv
// Saturating free-count unit: clamps the total and adds or removes a frame count.
module bfa_count_unit #(
	parameter int MAX_FRAMES = 32768
) (
	input  bfa_pkg::cnt_req_t req,
	output bfa_pkg::cnt_rsp_t rsp
);
	import bfa_pkg::*;

	logic [15:0] teff;
	logic [15:0] room;

	always_comb begin
		if (32'(req.total) > 32'(MAX_FRAMES)) begin
			teff = 16'(MAX_FRAMES);
		end else begin
			teff = req.total;
		end
		room = teff - req.fc;
		rsp.teff = teff;
		if (req.up) begin
			if (req.fc >= teff) begin
				rsp.fc = req.fc;
			end else if (32'(req.n) >= 32'(room)) begin
				rsp.fc = teff;
			end else begin
				rsp.fc = req.fc + 16'(req.n);
			end
		end else begin
			if (32'(req.n) >= 32'(req.fc)) begin
				rsp.fc = '0;
			end else begin
				rsp.fc = req.fc - 16'(req.n);
			end
		end
	end
endmodule

>>> design/bitmap_frame_allocator_unit.sv
// Top level of the bitmap frame allocator: request sequencer over the bitmap memory.
//
// One request is taken at a time; ready is high only while the sequencer is idle.
// After reset a fill pass writes every bitmap word to all-used, one word a cycle,
// before the first request is taken. Single-frame allocation reads the bitmap
// words in turn, reading each in S_SRD and testing it in S_SEV, until it finds a
// clear bit or reaches the end of the managed words. Run allocation walks the words
// the same way, skipping full and wholly free words and checking mixed words one
// bit a cycle, then marks the run. Frees and region updates set the new count, then
// read and rewrite each word touched in S_MRD and S_MWR; region updates then also
// set the bit of frame 0. The result is held in an output register, so the block
// returns to idle once it has been loaded. WORD_BITS must be a power of two.
module bitmap_frame_allocator_unit #(
	parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF,
	parameter int WORD_BITS   = bfa_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	bfa_req_if.sink     req,
	bfa_rsp_if.source   rsp
);
	import bfa_pkg::*;

	localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int WBL       = $clog2(WORD_BITS);
	localparam int FW        = $clog2(MAX_FRAMES);
	localparam logic [WORD_BITS-1:0] ALL = '1;

	typedef enum logic [12:0] {
		S_CLR  = 13'h0001,
		S_IDLE = 13'h0002,
		S_DISP = 13'h0004,
		S_SRD  = 13'h0008,
		S_SEV  = 13'h0010,
		S_RRD  = 13'h0020,
		S_REV  = 13'h0040,
		S_RBIT = 13'h0080,
		S_CNT  = 13'h0100,
		S_MRD  = 13'h0200,
		S_MWR  = 13'h0400,
		S_ZRD  = 13'h0800,
		S_ZWR  = 13'h1000
	} state_t;

	localparam state_t S_FIN = S_IDLE;

	state_t state_q;
	logic              fin_q;
	logic [2:0]        typ_q;
	logic [31:0]       addr_q;
	logic [31:0]       len_q;
	logic [15:0]       want_q;
	logic [AW:0]       w_q;
	logic [WBL-1:0]    b_q;
	logic [WORD_BITS-1:0] word_q;
	logic [16:0]       run_q;
	logic [FW-1:0]     start_q;
	logic [FW-1:0]     lo_q;
	logic [FW:0]       hi_q;
	logic              mval_q;
	logic              force0_q;
	logic [HITS_W-1:0] n_q;
	logic              up_q;
	logic [1:0]        status_q;
	logic [31:0]       res_q;
	logic [15:0]       fc_q;
	logic [15:0]       total_q;
	logic              ov_q;
	logic [1:0]        ostat_q;
	logic [31:0]       ores_q;
	logic [15:0]       ofree_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;
	cnt_req_t             cq;
	cnt_rsp_t             cr;

	logic [WBL-1:0]       fc_bit;
	logic [FW-1:0]        hit_f;
	logic [FW-1:0]        cur_f;
	logic [FW-1:0]        wbase;
	logic [15:0]          limw;
	logic                 at_end;
	logic [FW:0]          hm1;
	logic [WBL-1:0]       lo_in;
	logic [WBL-1:0]       hi_in;
	logic [WORD_BITS-1:0] mask;
	logic [FW-1:0]        run_st;
	logic [32:0]          rg_s;
	logic [32:0]          rg_n;
	logic [32:0]          rg_room;
	logic [32:0]          rg_hits;
	logic [32:0]          fr_one;

	bfa_bitmap_ram #(.DEPTH(NUM_WORDS), .WIDTH(WORD_BITS), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cq.fc    = fc_q;
	assign cq.total = total_q;
	assign cq.n     = n_q;
	assign cq.up    = up_q;

	bfa_count_unit #(.MAX_FRAMES(MAX_FRAMES)) u_cnt (
		.req (cq),
		.rsp (cr)
	);

	always_comb begin
		fc_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rdata[i]) begin
				fc_bit = WBL'(i);
			end
		end
	end

	assign hit_f  = FW'({w_q[AW-1:0], fc_bit});
	assign cur_f  = FW'({w_q[AW-1:0], b_q});
	assign wbase  = FW'({w_q[AW-1:0], {WBL{1'b0}}});
	assign limw   = cr.teff >> WBL;
	assign at_end = 32'(w_q) >= 32'(limw);
	assign run_st = (run_q == 17'd0) ? cur_f : start_q;

	// Mask of the bits of the current word that lie inside [lo, hi).
	always_comb begin
		hm1 = hi_q - 1'b1;
		lo_in = (32'(w_q) == 32'(lo_q >> WBL)) ? lo_q[WBL-1:0] : '0;
		hi_in = (32'(w_q) == 32'(hm1 >> WBL)) ? hm1[WBL-1:0] : WBL'(WORD_BITS - 1);
		mask = (ALL << lo_in) & (ALL >> (WBL'(WORD_BITS - 1) - hi_in));
	end

	always_comb begin
		rg_s    = 33'(addr_q >> FRAME_SHIFT);
		rg_n    = 33'(len_q >> FRAME_SHIFT);
		rg_room = 33'(MAX_FRAMES) - rg_s;
		if (rg_s >= 33'(MAX_FRAMES)) begin
			rg_hits = '0;
		end else if (rg_n < rg_room) begin
			rg_hits = rg_n;
		end else begin
			rg_hits = rg_room;
		end
		fr_one = 33'(addr_q >> FRAME_SHIFT);
	end

	always_comb begin
		we    = 1'b0;
		waddr = w_q[AW-1:0];
		wdata = ALL;
		raddr = w_q[AW-1:0];
		case (state_q)
			S_CLR: begin
				we = 1'b1;
			end
			S_MWR: begin
				we    = 1'b1;
				wdata = (rdata & ~mask) | (mval_q ? mask : '0);
			end
			S_ZRD: begin
				raddr = '0;
			end
			S_ZWR: begin
				we    = 1'b1;
				waddr = '0;
				wdata = rdata | WORD_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	assign req.ready          = (state_q == S_IDLE) && !fin_q;
	assign rsp.valid          = ov_q;
	assign rsp.status         = ostat_q;
	assign rsp.result_address = ores_q;
	assign rsp.free_frames    = ofree_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			typ_q  <= req.req_type;
			addr_q <= req.address;
			len_q  <= req.byte_length;
			want_q <= req.frame_count;
		end
		if (fin_q && (!ov_q || rsp.ready)) begin
			ostat_q <= status_q;
			ores_q  <= res_q;
			ofree_q <= fc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			fin_q    <= 1'b0;
			ov_q     <= 1'b0;
			fc_q     <= '0;
			w_q      <= '0;
			b_q      <= '0;
			word_q   <= '0;
			run_q    <= '0;
			start_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mval_q   <= 1'b0;
			force0_q <= 1'b0;
			n_q      <= '0;
			up_q     <= 1'b0;
			status_q <= ST_OK;
			res_q    <= '0;
		end else begin
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			// A finished request waits here until the output register is free.
			if (fin_q && (!ov_q || rsp.ready)) begin
				ov_q  <= 1'b1;
				fin_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					w_q <= w_q + 1'b1;
					if (w_q[AW-1:0] == AW'(NUM_WORDS - 1)) begin
						w_q     <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					status_q <= ST_OK;
					res_q    <= '0;
					w_q      <= '0;
					run_q    <= '0;
					force0_q <= 1'b0;
					case (typ_q)
						REQ_ALLOC_ONE: begin
							if (fc_q == 16'd0) begin
								status_q <= ST_NO_MEM;
								fin_q    <= 1'b1;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_SRD;
							end
						end
						REQ_ALLOC_RUN: begin
							if (want_q == 16'd0) begin
								status_q <= ST_ZERO_LEN;
								fin_q    <= 1'b1;
								state_q  <= S_FIN;
							end else if (fc_q == 16'd0) begin
								status_q <= ST_NO_MEM;
								fin_q    <= 1'b1;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_RRD;
							end
						end
						REQ_FREE_ONE: begin
							if (fr_one < 33'(MAX_FRAMES)) begin
								lo_q    <= FW'(fr_one);
								hi_q    <= (FW + 1)'(fr_one) + 1'b1;
								w_q     <= (AW + 1)'(fr_one >> WBL);
								mval_q  <= 1'b0;
								n_q     <= HITS_W'(1);
								up_q    <= 1'b1;
								state_q <= S_CNT;
							end else begin
								fin_q   <= 1'b1;
								state_q <= S_FIN;
							end
						end
						REQ_REGION_FREE, REQ_REGION_USED: begin
							lo_q     <= FW'(rg_s);
							hi_q     <= (FW + 1)'(rg_s + rg_hits);
							w_q      <= (AW + 1)'(rg_s >> WBL);
							mval_q   <= (typ_q == REQ_REGION_USED);
							up_q     <= (typ_q == REQ_REGION_FREE);
							n_q      <= HITS_W'(rg_hits);
							force0_q <= 1'b1;
							state_q  <= S_CNT;
						end
						default: begin
							fin_q   <= 1'b1;
							state_q <= S_FIN;
						end
					endcase
				end
				S_SRD: begin
					if (at_end) begin
						status_q <= ST_NO_MEM;
						fin_q    <= 1'b1;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_SEV;
					end
				end
				S_SEV: begin
					if (rdata != ALL) begin
						if (hit_f == '0) begin
							status_q <= ST_NO_MEM;
							fin_q    <= 1'b1;
							state_q  <= S_FIN;
						end else begin
							lo_q    <= hit_f;
							hi_q    <= (FW + 1)'(hit_f) + 1'b1;
							mval_q  <= 1'b1;
							n_q     <= HITS_W'(1);
							up_q    <= 1'b0;
							res_q   <= 32'({hit_f, {FRAME_SHIFT{1'b0}}});
							state_q <= S_CNT;
						end
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_RRD: begin
					if (at_end) begin
						status_q <= ST_NO_MEM;
						fin_q    <= 1'b1;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_REV;
					end
				end
				S_REV: begin
					word_q <= rdata;
					if (rdata == ALL) begin
						run_q   <= '0;
						w_q     <= w_q + 1'b1;
						state_q <= S_RRD;
					end else if (rdata == '0 &&
							(run_q + 17'(WORD_BITS)) < 17'(want_q)) begin
						// A wholly free word extends the run without ending it.
						if (run_q == 17'd0) begin
							start_q <= wbase;
						end
						run_q   <= run_q + 17'(WORD_BITS);
						w_q     <= w_q + 1'b1;
						state_q <= S_RRD;
					end else begin
						b_q     <= '0;
						state_q <= S_RBIT;
					end
				end
				S_RBIT: begin
					b_q <= b_q + 1'b1;
					if (b_q == WBL'(WORD_BITS - 1)) begin
						w_q     <= w_q + 1'b1;
						state_q <= S_RRD;
					end
					if (word_q[b_q]) begin
						run_q <= '0;
					end else begin
						start_q <= run_st;
						run_q   <= run_q + 1'b1;
						if ((run_q + 1'b1) == 17'(want_q)) begin
							if (run_st == '0) begin
								status_q <= ST_NO_MEM;
								fin_q    <= 1'b1;
								state_q  <= S_FIN;
							end else begin
								lo_q    <= run_st;
								hi_q    <= (FW + 1)'(run_st) + (FW + 1)'(want_q);
								w_q     <= (AW + 1)'(run_st >> WBL);
								mval_q  <= 1'b1;
								n_q     <= HITS_W'(want_q);
								up_q    <= 1'b0;
								res_q   <= 32'({run_st, {FRAME_SHIFT{1'b0}}});
								state_q <= S_CNT;
							end
						end
					end
				end
				S_CNT: begin
					fc_q <= cr.fc;
					if (n_q != '0) begin
						state_q <= S_MRD;
					end else if (force0_q) begin
						state_q <= S_ZRD;
					end else begin
						fin_q   <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (32'(w_q) == 32'(hm1 >> WBL)) begin
						if (force0_q) begin
							state_q <= S_ZRD;
						end else begin
							fin_q   <= 1'b1;
							state_q <= S_FIN;
						end
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				S_ZRD: begin
					state_q <= S_ZWR;
				end
				S_ZWR: begin
					fin_q   <= 1'b1;
					state_q <= S_FIN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> design/bfa_checker.sv
// Port-level checker of the frame allocator and its bind to the top level.
`include "bitmap_frame_allocator_unit_defines.svh"

module bfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [31:0] result_address,
	input logic [15:0] free_frames
);
	import bfa_pkg::*;

	`BFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(result_address) && $stable(free_frames), "response changed while stalled")
	`BFA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "block ready again straight after a request")
	`BFA_ASSERT_NOW(a_fail_zero_addr, rsp_valid && status != ST_OK, result_address == 32'd0, "failed request returned an address")
	`BFA_ASSERT_NOW(a_status_code, rsp_valid, status == ST_OK || status == ST_NO_MEM || status == ST_ZERO_LEN, "undefined status code")
endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.result_address (rsp.result_address),
	.free_frames    (rsp.free_frames)
);

>>> dv/tb_bitmap_frame_allocator_unit.sv
// Testbench of the bitmap frame allocator: random and directed requests checked against a predictor.
module tb_bitmap_frame_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import bfa_pkg::*;

	localparam int NFRAMES = 32768;
	localparam int SHIFT = 12;
	localparam longint CYCLE_LIMIT = 200_000_000;

	typedef struct {
		logic [2:0]  req_type;
		logic [31:0] address;
		logic [31:0] byte_length;
		logic [15:0] frame_count;
	} alloc_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic [15:0] free_frames;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	bfa_req_if req_ch ();
	bfa_rsp_if rsp_ch ();

	bitmap_frame_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// Predictor state
	bit          used_map [NFRAMES];
	int unsigned free_cnt;
	int unsigned total_reg;

	alloc_req_t pending_reqs[$];
	alloc_rsp_t awaited_rsps[$];

	int     mismatches;
	bit     req_fire;
	bit     sender_hold;
	int     burst_left;
	int     gap_left;
	int     long_hold;
	int     rdy_mode;
	logic [15:0] rdy_pat;
	longint cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int unsigned total_eff();
		return (total_reg > NFRAMES) ? NFRAMES : total_reg;
	endfunction

	function automatic void count_up(longint unsigned n);
		int unsigned t;
		t = total_eff();
		if (free_cnt >= t)
			return;
		if (n >= t - free_cnt)
			free_cnt = t;
		else
			free_cnt += n;
	endfunction

	function automatic void count_down(longint unsigned n);
		if (n >= free_cnt)
			free_cnt = 0;
		else
			free_cnt -= n;
	endfunction

	function automatic void mark_region(longint unsigned start, longint unsigned n, bit used);
		longint unsigned hits;
		hits = 0;
		if (start < NFRAMES) begin
			hits = NFRAMES - start;
			if (n < hits)
				hits = n;
			for (longint unsigned f = start; f < start + hits; f++)
				used_map[f] = used;
		end
		if (used)
			count_down(hits);
		else
			count_up(hits);
		used_map[0] = 1'b1;
	endfunction

	// Applies one request to the predicted bitmap and returns the response it should give.
	function automatic alloc_rsp_t apply_request(alloc_req_t r);
		alloc_rsp_t  o;
		int unsigned lim;
		int unsigned hit;
		int unsigned run;
		int unsigned first;
		bit          found;
		longint unsigned fr;
		o.status = ST_OK;
		o.result_address = '0;
		lim = (total_eff() / 32) * 32;
		found = 1'b0;
		hit = 0;
		run = 0;
		first = 0;
		case (r.req_type)
			REQ_ALLOC_ONE: begin
				if (free_cnt != 0) begin
					for (int unsigned f = 0; f < lim; f++) begin
						if (!used_map[f]) begin
							found = 1'b1;
							hit = f;
							break;
						end
					end
				end
				if (!found || hit == 0) begin
					o.status = ST_NO_MEM;
				end else begin
					used_map[hit] = 1'b1;
					count_down(1);
					o.result_address = 32'(hit << SHIFT);
				end
			end
			REQ_ALLOC_RUN: begin
				if (r.frame_count == 0) begin
					o.status = ST_ZERO_LEN;
				end else if (free_cnt == 0) begin
					o.status = ST_NO_MEM;
				end else begin
					for (int unsigned f = 0; f < lim; f++) begin
						if (used_map[f]) begin
							run = 0;
							continue;
						end
						if (run == 0)
							first = f;
						run++;
						if (run == r.frame_count) begin
							found = 1'b1;
							break;
						end
					end
					if (!found || first == 0) begin
						o.status = ST_NO_MEM;
					end else begin
						for (int unsigned f = first; f < first + r.frame_count; f++)
							used_map[f] = 1'b1;
						count_down(r.frame_count);
						o.result_address = 32'(first << SHIFT);
					end
				end
			end
			REQ_FREE_ONE: begin
				fr = r.address >> SHIFT;
				if (fr < NFRAMES) begin
					used_map[fr] = 1'b0;
					count_up(1);
				end
			end
			REQ_REGION_FREE: mark_region(r.address >> SHIFT, r.byte_length >> SHIFT, 1'b0);
			REQ_REGION_USED: mark_region(r.address >> SHIFT, r.byte_length >> SHIFT, 1'b1);
			default: ;
		endcase
		o.free_frames = free_cnt[15:0];
		return o;
	endfunction

	function automatic alloc_req_t mk(logic [2:0] t, logic [31:0] a, logic [31:0] l,
			logic [15:0] c);
		alloc_req_t r;
		r.req_type = t;
		r.address = a;
		r.byte_length = l;
		r.frame_count = c;
		return r;
	endfunction

	// Mostly well-formed requests aimed at the managed frames, with some noise.
	function automatic alloc_req_t random_request();
		alloc_req_t  r;
		int unsigned span;
		int unsigned sel;
		span = total_eff() + 16;
		if (span < 48)
			span = 48;
		r = mk(3'($urandom_range(0, 4)), 32'($urandom_range(0, span - 1)) << SHIFT,
			32'($urandom_range(0, 8)) << SHIFT, 16'($urandom_range(1, 8)));
		r.address[11:0] = 12'($urandom);
		r.byte_length[11:0] = 12'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 3)
			r.req_type = 3'($urandom_range(5, 7));
		else if (sel < 8)
			r.address = $urandom;
		else if (sel < 11)
			r.byte_length = $urandom;
		else if (sel < 15)
			r.frame_count = 16'($urandom);
		else if (sel < 19)
			r.frame_count = 16'($urandom_range(0, 40));
		// Occasional full-length regions from the bottom, to refill or drain the map
		if (r.req_type >= REQ_REGION_FREE && r.req_type <= REQ_REGION_USED && sel >= 95) begin
			r.address = '0;
			r.byte_length = 32'(span) << SHIFT;
		end
		return r;
	endfunction

	// Driver: requests change at the falling edge, in bursts with gaps.
	always @(negedge clk) begin
		logic       drive;
		alloc_req_t r;
		drive = req_ch.valid;
		if (req_fire) begin
			void'(pending_reqs.pop_front());
			drive = 1'b0;
		end
		if (!drive) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() > 0 && !sender_hold) begin
				drive = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				end
			end
		end
		if (drive) begin
			r = pending_reqs[0];
			req_ch.req_type = r.req_type;
			req_ch.address = r.address;
			req_ch.byte_length = r.byte_length;
			req_ch.frame_count = r.frame_count;
		end
		req_ch.valid = drive;
	end

	// Receiver: its own stall pattern, plus a long hold-off when asked.
	always @(negedge clk) begin
		if (long_hold > 0) begin
			long_hold--;
			rsp_ch.ready = 1'b0;
		end else begin
			rdy_pat = {rdy_pat[14:0], rdy_pat[15]};
			case (rdy_mode)
				0: rsp_ch.ready = 1'b1;
				1: rsp_ch.ready = ($urandom_range(0, 9) < 7);
				default: rsp_ch.ready = rdy_pat[0];
			endcase
		end
	end

	// Monitor: predicts on each accepted request and checks each accepted response.
	always @(posedge clk) begin
		alloc_req_t r;
		alloc_rsp_t e;
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		if (req_fire) begin
			r.req_type = req_ch.req_type;
			r.address = req_ch.address;
			r.byte_length = req_ch.byte_length;
			r.frame_count = req_ch.frame_count;
			awaited_rsps.push_back(apply_request(r));
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status %0d addr %h free %0d",
						rsp_ch.status, rsp_ch.result_address, rsp_ch.free_frames);
			end else begin
				e = awaited_rsps.pop_front();
				if (rsp_ch.status !== e.status || rsp_ch.result_address !== e.result_address
						|| rsp_ch.free_frames !== e.free_frames) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
							e.status, e.result_address, e.free_frames,
							rsp_ch.status, rsp_ch.result_address, rsp_ch.free_frames);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[bitmap_frame_allocator_unit] ERROR");
			$finish;
		end
	end

	task automatic wait_idle();
		wait (pending_reqs.size() == 0 && !req_ch.valid && awaited_rsps.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_total(logic [15:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		total_reg = v;
	endtask

	task automatic random_phase(logic [15:0] tot, int n, int mode);
		wait_idle();
		write_total(tot);
		rdy_mode = mode;
		rdy_pat = 16'($urandom) | 16'h0101;
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(random_request());
	endtask

	initial begin
		logic [15:0] totals [10];
		int          counts [10];
		cycles = 0;
		mismatches = 0;
		req_fire = 1'b0;
		sender_hold = 1'b0;
		burst_left = 0;
		gap_left = 0;
		long_hold = 0;
		rdy_mode = 0;
		rdy_pat = 16'hA5A5;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.address = '0;
		req_ch.byte_length = '0;
		req_ch.frame_count = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < NFRAMES; i++)
			used_map[i] = 1'b1;
		free_cnt = 0;
		total_reg = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// The fill pass after reset keeps ready low until the bitmap is cleared to used.
		wait (req_ch.ready === 1'b1);

		write_total(16'd64);
		rdy_mode = 1;
		pending_reqs.push_back(mk(REQ_ALLOC_ONE, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_RUN, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_RUN, 0, 0, 1));
		pending_reqs.push_back(mk(REQ_REGION_FREE, 0, 64 << SHIFT, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_ONE, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_RUN, 0, 0, 5));
		pending_reqs.push_back(mk(REQ_ALLOC_RUN, 0, 0, 60));
		pending_reqs.push_back(mk(REQ_FREE_ONE, 32'h0000_1FFF, 0, 0));
		pending_reqs.push_back(mk(REQ_FREE_ONE, 32'h0000_1FFF, 0, 0));
		// Freeing frame 0 lets the single search land on it, which must fail.
		pending_reqs.push_back(mk(REQ_FREE_ONE, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_ONE, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_REGION_USED, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_FREE_ONE, 32'hFFFF_FFFF, 0, 0));
		pending_reqs.push_back(mk(REQ_REGION_FREE, 32'hFFFF_F000, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(REQ_REGION_USED, 32767 << SHIFT, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(3'd5, 32'h1234_5000, 32'h8000, 16'h8000));
		pending_reqs.push_back(mk(3'd6, 0, 0, 0));
		pending_reqs.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		pending_reqs.push_back(mk(REQ_ALLOC_RUN, 0, 0, 16'hFFFF));
		pending_reqs.push_back(mk(REQ_REGION_USED, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_ONE, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_REGION_FREE, 0, 64 << SHIFT, 0));
		pending_reqs.push_back(mk(REQ_ALLOC_RUN, 0, 0, 32));
		pending_reqs.push_back(mk(REQ_ALLOC_ONE, 0, 0, 0));

		totals = '{16'd100, 16'd1024, 16'd16, 16'd0, 16'd300, 16'd65535, 16'd40,
			16'd2048, 16'd32768, 16'd513};
		counts = '{190, 200, 160, 156, 200, 70, 200, 190, 60, 200};
		for (int p = 0; p < 10; p++) begin
			random_phase(totals[p], counts[p], p % 3);
			if (p == 1)
				long_hold = 600;
			if (p == 4) begin
				// Let half of the phase go, then hold the sender until the block has drained.
				wait (pending_reqs.size() < counts[p] / 2);
				sender_hold = 1'b1;
				wait (awaited_rsps.size() == 0 && !req_ch.valid);
				repeat (20) @(posedge clk);
				sender_hold = 1'b0;
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && awaited_rsps.size() == 0)
			$display("[bitmap_frame_allocator_unit] OK");
		else
			$display("[bitmap_frame_allocator_unit] ERROR");
		$finish;
	end
endmodule

>>> files.f
+incdir+design
design/bfa_pkg.sv
design/bfa_if.sv
design/bfa_bitmap_ram.sv
design/bfa_count_unit.sv
design/bitmap_frame_allocator_unit.sv
design/bfa_checker.sv
dv/tb_bitmap_frame_allocator_unit.sv
